// ===== src/circular_fifo_queue_core_macros.svh =====
// Assertion macros shared by the circular FIFO queue RTL.
`ifndef CIRCULAR_FIFO_QUEUE_CORE_MACROS_SVH
`define CIRCULAR_FIFO_QUEUE_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define CFQ_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define CFQ_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define CFQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define CFQ_ASSERT_ALWAYS(label, cond, msg)
`define CFQ_ASSERT_IMPLY(label, ante, cons, msg)
`define CFQ_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== src/cfq_pkg.sv =====
// Constants, codes and helper functions of the circular FIFO queue.
package cfq_pkg;

   localparam int DEPTH      = 64;
   localparam int DATA_WIDTH = 32;
   localparam int SLOT_W     = $clog2(DEPTH);
   localparam int COUNT_W    = $clog2(DEPTH + 1);
   localparam int CAP_W      = 7;
   localparam int ACTION_W   = 3;
   localparam int POS_W      = 6;
   localparam int STATUS_W   = 2;

   localparam int MOD_W      = SLOT_W + 1;
   localparam int MOD_STEPS  = MOD_W;
   localparam int STEP_W     = $clog2(MOD_STEPS);
   localparam int MOD_CMP_W  = COUNT_W + MOD_STEPS;

   localparam logic [ACTION_W-1:0] ACT_ENQUEUE  = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_DEQUEUE  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_FRONT    = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_REAR     = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_CONTAINS = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_GET_AT   = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd6;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd10;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MOD  = 5'b00010,
      ST_READ = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   // Clamps the programmed capacity to the range one to the built depth.
   function automatic logic [COUNT_W-1:0] cfq_eff_cap(input logic [CAP_W-1:0] cap);
      logic [COUNT_W-1:0] c;
      if (cap == '0) begin
         c = COUNT_W'(1);
      end else if (COUNT_W'(cap) > COUNT_W'(DEPTH)) begin
         c = COUNT_W'(DEPTH);
      end else begin
         c = COUNT_W'(cap);
      end
      return c;
   endfunction

   // Steps a ring pointer on by one, wrapping to slot zero at the capacity.
   function automatic logic [SLOT_W-1:0] cfq_advance(input logic [SLOT_W-1:0] slot,
                                                     input logic [COUNT_W-1:0] cap);
      logic [COUNT_W-1:0] n;
      n = COUNT_W'(slot) + COUNT_W'(1);
      return (n >= cap) ? '0 : n[SLOT_W-1:0];
   endfunction

endpackage

// ===== src/circular_fifo_queue_core.sv =====
// Top level of the circular FIFO queue: control, ring storage and result register.
//
// Usage: each request transfer on the req_ channel carries one action (enqueue,
// dequeue, front, rear, contains, get at position or clear) with its value and
// position. Every request yields exactly one response transfer on the rsp_
// channel with data, found flag, status, element count and empty and full flags.
// The csr_ channel writes the capacity in use; it is always ready and should be
// written only while the block is idle.
// Enqueue, clear and failed actions go from the work registers straight to the
// response register; dequeue, front and rear first read the synchronous storage
// memory; get at position first reduces the slot modulo the capacity in a
// seven-step subtract unit and then reads the memory; contains reduces the front
// slot the same way and then walks the memory one element a cycle.
// One request is in work at a time; the next is taken once the previous one
// has reached the response register.
// A stalled receiver holds the response register; a following request is
// still taken and completes up to that register.
// Reset clears the pointers, the count and the response valid, and sets the
// capacity to ten; storage content is not cleared and needs no clearing pass.
module circular_fifo_queue_core
   import cfq_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic        [ACTION_W-1:0]   req_action,
   input  logic signed [DATA_WIDTH-1:0] req_value,
   input  logic        [POS_W-1:0]      req_position,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_data,
   output logic                         rsp_found,
   output logic        [STATUS_W-1:0]   rsp_status,
   output logic        [COUNT_W-1:0]    rsp_count,
   output logic                         rsp_is_empty,
   output logic                         rsp_is_full,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic        [CAP_W-1:0]      csr_capacity_in_use
);

`include "circular_fifo_queue_core_macros.svh"

   state_type                state_ff, state_in;
   logic [SLOT_W-1:0]        front_ff, front_in;
   logic [SLOT_W-1:0]        write_ff, write_in;
   logic [COUNT_W-1:0]       count_ff, count_in;
   logic [CAP_W-1:0]         cap_ff;
   logic [ACTION_W-1:0]      action_ff, action_in;
   logic [DATA_WIDTH-1:0]    value_ff, value_in;
   logic [MOD_W-1:0]         rem_ff, rem_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [COUNT_W-1:0]       left_ff, left_in;
   logic [SLOT_W-1:0]        scan_ff, scan_in;
   logic [DATA_WIDTH-1:0]    work_data_ff, work_data_in;
   logic                     work_found_ff, work_found_in;
   logic [STATUS_W-1:0]      work_status_ff, work_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]    rsp_data_ff;
   logic                     rsp_found_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic                     rsp_is_empty_ff;
   logic                     rsp_is_full_ff;
   logic [DATA_WIDTH-1:0]    rd_data_ff;

   logic [DATA_WIDTH-1:0]    mem [DEPTH];
   logic                     mem_we;
   logic [SLOT_W-1:0]        mem_waddr;
   logic                     rd_en;
   logic [SLOT_W-1:0]        rd_addr;

   logic [COUNT_W-1:0]       eff_cap;
   logic                     is_empty;
   logic                     is_full;
   logic                     req_take;
   logic                     rsp_load;
   logic [MOD_CMP_W-1:0]     trial;
   logic [MOD_CMP_W-1:0]     rem_ext;
   logic [MOD_W-1:0]         rem_step;
   logic [SLOT_W-1:0]        rear_slot;

   assign eff_cap   = cfq_eff_cap(cap_ff);
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff >= eff_cap);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign trial     = MOD_CMP_W'(eff_cap) << step_ff;
   assign rem_ext   = MOD_CMP_W'(rem_ff);
   assign rem_step  = (rem_ext >= trial) ? MOD_W'(rem_ext - trial) : rem_ff;
   assign rear_slot = (write_ff == '0) ? SLOT_W'(eff_cap - COUNT_W'(1))
                                       : write_ff - SLOT_W'(1);

   always_comb begin
      state_in       = state_ff;
      front_in       = front_ff;
      write_in       = write_ff;
      count_in       = count_ff;
      action_in      = action_ff;
      value_in       = value_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      left_in        = left_ff;
      scan_in        = scan_ff;
      work_data_in   = work_data_ff;
      work_found_in  = work_found_ff;
      work_status_in = work_status_ff;
      mem_we         = 1'b0;
      mem_waddr      = write_ff;
      rd_en          = 1'b0;
      rd_addr        = front_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               action_in      = req_action;
               value_in       = req_value;
               work_data_in   = '0;
               work_found_in  = 1'b0;
               work_status_in = STAT_OK;
               state_in       = ST_DONE;
               case (req_action)
                  ACT_ENQUEUE: begin
                     if (is_full) begin
                        work_status_in = STAT_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        write_in = cfq_advance(write_ff, eff_cap);
                        count_in = count_ff + COUNT_W'(1);
                     end
                  end
                  ACT_DEQUEUE: begin
                     if (is_empty) begin
                        work_status_in = STAT_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        front_in = cfq_advance(front_ff, eff_cap);
                        count_in = count_ff - COUNT_W'(1);
                        state_in = ST_READ;
                     end
                  end
                  ACT_FRONT: begin
                     if (is_empty) begin
                        work_status_in = STAT_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = ST_READ;
                     end
                  end
                  ACT_REAR: begin
                     if (is_empty) begin
                        work_status_in = STAT_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = rear_slot;
                        state_in = ST_READ;
                     end
                  end
                  ACT_CONTAINS: begin
                     if (!is_empty) begin
                        rem_in   = MOD_W'(front_ff);
                        step_in  = STEP_W'(MOD_STEPS - 1);
                        state_in = ST_MOD;
                     end
                  end
                  ACT_GET_AT: begin
                     if (COUNT_W'(req_position) >= count_ff) begin
                        work_status_in = STAT_RANGE;
                     end else begin
                        rem_in   = MOD_W'(front_ff) + MOD_W'(req_position);
                        step_in  = STEP_W'(MOD_STEPS - 1);
                        state_in = ST_MOD;
                     end
                  end
                  ACT_CLEAR: begin
                     front_in = '0;
                     write_in = '0;
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MOD: begin
            rem_in  = rem_step;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               rd_en   = 1'b1;
               rd_addr = rem_step[SLOT_W-1:0];
               if (action_ff == ACT_CONTAINS) begin
                  scan_in  = cfq_advance(rem_step[SLOT_W-1:0], eff_cap);
                  left_in  = count_ff - COUNT_W'(1);
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            work_data_in = rd_data_ff;
            state_in     = ST_DONE;
         end
         ST_SCAN: begin
            if (rd_data_ff == value_ff) begin
               work_found_in = 1'b1;
               state_in      = ST_DONE;
            end else if (left_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = scan_ff;
               scan_in = cfq_advance(scan_ff, eff_cap);
               left_in = left_ff - COUNT_W'(1);
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         write_ff     <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         write_ff     <= write_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_capacity_in_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      value_ff       <= value_in;
      rem_ff         <= rem_in;
      step_ff        <= step_in;
      left_ff        <= left_in;
      scan_ff        <= scan_in;
      work_data_ff   <= work_data_in;
      work_found_ff  <= work_found_in;
      work_status_ff <= work_status_in;
      if (rsp_load) begin
         rsp_data_ff     <= work_data_ff;
         rsp_found_ff    <= work_found_ff;
         rsp_status_ff   <= work_status_ff;
         rsp_count_ff    <= count_ff;
         rsp_is_empty_ff <= is_empty;
         rsp_is_full_ff  <= is_full;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_is_empty = rsp_is_empty_ff;
   assign rsp_is_full  = rsp_is_full_ff;

   `CFQ_ASSERT_ALWAYS(a_count_bound, count_ff <= COUNT_W'(DEPTH), "Element count above depth.")
   `CFQ_ASSERT_IMPLY(a_scan_slot, state_ff == ST_SCAN, scan_ff < eff_cap, "Scan slot past capacity.")
   `CFQ_ASSERT_NEXT(a_enqueue_count, req_take && req_action == ACT_ENQUEUE && !is_full, count_ff == $past(count_ff) + COUNT_W'(1), "Enqueue did not raise the count.")
   `CFQ_ASSERT_IMPLY(a_full_status, rsp_valid_ff && rsp_status_ff == STAT_FULL, rsp_is_full_ff, "Full status without full flag.")

endmodule
